// ----- rtl/scc_pkg.sv -----
// Shared types, stage counts and saturation helper for the sphere/capsule test.
// Used by every module of the sphere_capsule_collision pipeline.
`default_nettype none
package scc_pkg;

    localparam int unsigned TDIV_STEPS = 30;
    localparam int unsigned SQRT_STEPS = 32;
    localparam int unsigned NORM_STEPS = 15;

    localparam logic [1:0] TSEL_DIV  = 2'd0;
    localparam logic [1:0] TSEL_ZERO = 2'd1;
    localparam logic [1:0] TSEL_ONE  = 2'd2;

    localparam logic signed [33:0] SAT_HI = 34'sd2147483647;
    localparam logic signed [33:0] SAT_LO = -34'sd2147483648;

    // first member sits in the highest bits: fields listed last to first
    typedef struct packed {
        logic [30:0] cap_radius;
        logic [30:0] cap_length;
        logic [15:0] cap_dir_z;
        logic [15:0] cap_dir_y;
        logic [15:0] cap_dir_x;
        logic [31:0] cap_center_z;
        logic [31:0] cap_center_y;
        logic [31:0] cap_center_x;
        logic [30:0] sphere_radius;
        logic [31:0] sphere_z;
        logic [31:0] sphere_y;
        logic [31:0] sphere_x;
    } t_item;

    typedef struct packed {
        logic [2:0][31:0] s;
        logic [2:0][31:0] o;
        logic [2:0][32:0] d;
        logic [31:0]      rsum;
    } t_seg;

    typedef struct packed {
        t_seg        seg;
        logic [61:0] len2;
        logic [63:0] dp;
    } t_proj;

    typedef struct packed {
        t_seg        seg;
        logic [30:0] t;
    } t_para;

    typedef struct packed {
        logic [2:0][31:0] m;
        logic [2:0]       neg;
        logic [31:0]      rsum;
        logic             hit;
        logic             zero;
    } t_side;

    typedef struct packed {
        t_side       side;
        logic [63:0] dist2;
    } t_near;

    typedef struct packed {
        t_side       side;
        logic [31:0] mag;
    } t_root;

    typedef struct packed {
        logic             hit;
        logic [30:0]      depth;
        logic [2:0][15:0] push;
    } t_res;

    function automatic logic [31:0] sat32(input logic signed [33:0] x);
        if (x > SAT_HI) begin
            return 32'h7FFF_FFFF;
        end
        if (x < SAT_LO) begin
            return 32'h8000_0000;
        end
        return x[31:0];
    endfunction

endpackage
`default_nettype wire

// ----- rtl/scc_front.sv -----
// Front stages: segment ends, projection operands, len2 and dot product sums.
// Depends on scc_pkg.
`default_nettype none
module scc_front import scc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_item i_item,
    output logic  o_valid,
    output t_proj o_proj
);
    logic [2:0][15:0] w_dir;
    logic [2:0][31:0] w_s;
    logic [2:0][31:0] w_c;
    logic signed [47:0] n_eprod [3];
    logic [2:0][32:0] n_e1;
    logic signed [33:0] n_lo [3];
    logic signed [33:0] n_hi [3];
    logic [2:0][31:0] n_o2;
    logic [2:0][31:0] n_end2;
    logic signed [32:0] n_d2 [3];
    logic signed [32:0] n_w2 [3];
    logic [2:0][30:0] n_a2;
    logic [2:0][30:0] n_b2;
    logic [2:0][61:0] n_aa3;
    logic [2:0][61:0] n_ab3;
    logic [2:0][32:0] n_dv2;

    logic             r_vld1, r_vld2, r_vld3, r_vld4;
    logic [2:0][32:0] r_e1;
    logic [2:0][31:0] r_s1, r_c1;
    logic [31:0]      r_rsum1;
    t_seg             r_seg2, r_seg3;
    logic [2:0][30:0] r_a2, r_b2;
    logic [2:0][61:0] r_aa3, r_ab3;
    t_proj            r_proj4;

    assign w_dir = {i_item.cap_dir_z, i_item.cap_dir_y, i_item.cap_dir_x};
    assign w_s   = {i_item.sphere_z, i_item.sphere_y, i_item.sphere_x};
    assign w_c   = {i_item.cap_center_z, i_item.cap_center_y, i_item.cap_center_x};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_eprod[i] = 48'($signed(w_dir[i])) * 48'($signed({1'b0, i_item.cap_length}));
            n_e1[i]    = 33'(n_eprod[i] >>> 15);
            n_lo[i]    = 34'($signed(r_c1[i])) - 34'($signed(r_e1[i]));
            n_hi[i]    = 34'($signed(r_c1[i])) + 34'($signed(r_e1[i]));
            n_o2[i]    = sat32(n_lo[i]);
            n_end2[i]  = sat32(n_hi[i]);
            n_d2[i]    = 33'($signed(n_end2[i])) - 33'($signed(n_o2[i]));
            n_w2[i]    = 33'($signed(r_s1[i])) - 33'($signed(n_o2[i]));
            n_dv2[i]   = n_d2[i];
            n_a2[i]    = 31'(n_d2[i] >>> 2);
            n_b2[i]    = 31'(n_w2[i] >>> 2);
            n_aa3[i]   = 62'($signed(r_a2[i])) * 62'($signed(r_a2[i]));
            n_ab3[i]   = 62'($signed(r_a2[i])) * 62'($signed(r_b2[i]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_valid;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
            r_vld4 <= r_vld3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e1    <= n_e1;
            r_s1    <= w_s;
            r_c1    <= w_c;
            r_rsum1 <= 32'(i_item.sphere_radius) + 32'(i_item.cap_radius);

            r_seg2.s    <= r_s1;
            r_seg2.o    <= n_o2;
            r_seg2.d    <= n_dv2;
            r_seg2.rsum <= r_rsum1;
            r_a2        <= n_a2;
            r_b2        <= n_b2;

            r_seg3 <= r_seg2;
            r_aa3  <= n_aa3;
            r_ab3  <= n_ab3;

            r_proj4.seg  <= r_seg3;
            r_proj4.len2 <= r_aa3[0] + r_aa3[1] + r_aa3[2];
            r_proj4.dp   <= 64'($signed(r_ab3[0])) + 64'($signed(r_ab3[1]))
                          + 64'($signed(r_ab3[2]));
        end
    end

    assign o_valid = r_vld4;
    assign o_proj  = r_proj4;
endmodule
`default_nettype wire

// ----- rtl/scc_tdiv.sv -----
// Clamped segment parameter t in Q1.30, one quotient bit per stage.
// Depends on scc_pkg.
`default_nettype none
module scc_tdiv import scc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_proj i_proj,
    output logic  o_valid,
    output t_para o_para
);
    logic [1:0]  n_tsel0;
    logic [62:0] n_rem [TDIV_STEPS];
    logic [29:0] n_q   [TDIV_STEPS];
    logic [62:0] n_sh  [TDIV_STEPS];

    logic        r_vld0;
    logic [1:0]  r_tsel0;
    logic [61:0] r_den0;
    logic [62:0] r_rem0;
    t_seg        r_seg0;

    logic        r_vld  [TDIV_STEPS];
    logic [1:0]  r_tsel [TDIV_STEPS];
    logic [61:0] r_den  [TDIV_STEPS];
    logic [62:0] r_rem  [TDIV_STEPS];
    logic [29:0] r_q    [TDIV_STEPS];
    t_seg        r_seg  [TDIV_STEPS];

    always_comb begin
        if (i_proj.len2 == 62'd0 || $signed(i_proj.dp) <= 64'sd0) begin
            n_tsel0 = TSEL_ZERO;
        end else if ($signed(i_proj.dp) >= $signed({2'b00, i_proj.len2})) begin
            n_tsel0 = TSEL_ONE;
        end else begin
            n_tsel0 = TSEL_DIV;
        end
        n_sh[0] = r_rem0 << 1;
        if (n_sh[0] >= 63'(r_den0)) begin
            n_rem[0] = n_sh[0] - 63'(r_den0);
            n_q[0]   = 30'd1;
        end else begin
            n_rem[0] = n_sh[0];
            n_q[0]   = 30'd0;
        end
        for (int k = 1; k < TDIV_STEPS; k++) begin
            n_sh[k] = r_rem[k-1] << 1;
            if (n_sh[k] >= 63'(r_den[k-1])) begin
                n_rem[k] = n_sh[k] - 63'(r_den[k-1]);
                n_q[k]   = {r_q[k-1][28:0], 1'b1};
            end else begin
                n_rem[k] = n_sh[k];
                n_q[k]   = {r_q[k-1][28:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
            for (int k = 0; k < TDIV_STEPS; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld0   <= i_valid;
            r_vld[0] <= r_vld0;
            for (int k = 1; k < TDIV_STEPS; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tsel0 <= n_tsel0;
            r_den0  <= i_proj.len2;
            r_rem0  <= (n_tsel0 == TSEL_DIV) ? i_proj.dp[62:0] : 63'd0;
            r_seg0  <= i_proj.seg;
            r_tsel[0] <= r_tsel0;
            r_den[0]  <= r_den0;
            r_rem[0]  <= n_rem[0];
            r_q[0]    <= n_q[0];
            r_seg[0]  <= r_seg0;
            for (int k = 1; k < TDIV_STEPS; k++) begin
                r_tsel[k] <= r_tsel[k-1];
                r_den[k]  <= r_den[k-1];
                r_rem[k]  <= n_rem[k];
                r_q[k]    <= n_q[k];
                r_seg[k]  <= r_seg[k-1];
            end
        end
    end

    always_comb begin
        o_para.seg = r_seg[TDIV_STEPS-1];
        case (r_tsel[TDIV_STEPS-1])
            TSEL_ZERO: o_para.t = 31'd0;
            TSEL_ONE:  o_para.t = 31'h4000_0000;
            default:   o_para.t = {1'b0, r_q[TDIV_STEPS-1]};
        endcase
    end

    assign o_valid = r_vld[TDIV_STEPS-1];
endmodule
`default_nettype wire

// ----- rtl/scc_close.sv -----
// Closest point on the segment, offset vector, squared distance and overlap flag.
// Depends on scc_pkg.
`default_nettype none
module scc_close import scc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_para i_para,
    output logic  o_valid,
    output t_near o_near
);
    logic signed [64:0] n_prod1 [3];
    logic signed [34:0] n_p2    [3];
    logic signed [35:0] n_v2    [3];
    logic [2:0][31:0]   n_m2;
    logic [2:0]         n_neg2;
    logic [65:0]        n_sum4;
    logic [63:0]        n_dist4;
    t_side              n_side4;

    logic               r_vld1, r_vld2, r_vld3, r_vld4;
    logic signed [64:0] r_prod1 [3];
    t_seg               r_seg1;
    logic [2:0][31:0]   r_m2;
    logic [2:0]         r_neg2;
    logic [31:0]        r_rsum2;
    logic [2:0][63:0]   r_sq3;
    logic [63:0]        r_r2_3;
    t_side              r_side3;
    t_near              r_near4;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_prod1[i] = 65'($signed(i_para.seg.d[i])) * 65'($signed({1'b0, i_para.t}));
            n_p2[i]    = 35'($signed(r_seg1.o[i])) + 35'(r_prod1[i] >>> 30);
            n_v2[i]    = 36'($signed(r_seg1.s[i])) - 36'(n_p2[i]);
            n_neg2[i]  = n_v2[i][35];
            n_m2[i]    = n_v2[i][35] ? 32'(-n_v2[i]) : n_v2[i][31:0];
        end
        n_sum4       = 66'(r_sq3[0]) + 66'(r_sq3[1]) + 66'(r_sq3[2]);
        n_dist4      = (n_sum4[65:64] != 2'd0) ? '1 : n_sum4[63:0];
        n_side4      = r_side3;
        n_side4.hit  = n_dist4 < r_r2_3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_valid;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
            r_vld4 <= r_vld3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_prod1[i] <= n_prod1[i];
                r_sq3[i]   <= 64'(r_m2[i]) * 64'(r_m2[i]);
            end
            r_seg1  <= i_para.seg;
            r_m2    <= n_m2;
            r_neg2  <= n_neg2;
            r_rsum2 <= r_seg1.rsum;

            r_r2_3       <= 64'(r_rsum2) * 64'(r_rsum2);
            r_side3.m    <= r_m2;
            r_side3.neg  <= r_neg2;
            r_side3.rsum <= r_rsum2;
            r_side3.hit  <= 1'b0;
            r_side3.zero <= (r_m2 == '0);

            r_near4.side  <= n_side4;
            r_near4.dist2 <= n_dist4;
        end
    end

    assign o_valid = r_vld4;
    assign o_near  = r_near4;
endmodule
`default_nettype wire

// ----- rtl/scc_sqrt.sv -----
// Integer square root of the squared distance, one result bit per stage.
// Depends on scc_pkg.
`default_nettype none
module scc_sqrt import scc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_near i_near,
    output logic  o_valid,
    output t_root o_root
);
    logic [63:0] c_x   [SQRT_STEPS];
    logic [63:0] c_res [SQRT_STEPS];
    logic [63:0] c_bit [SQRT_STEPS];
    logic [63:0] n_x   [SQRT_STEPS];
    logic [63:0] n_res [SQRT_STEPS];

    logic        r_vld  [SQRT_STEPS];
    logic [63:0] r_x    [SQRT_STEPS];
    logic [63:0] r_res  [SQRT_STEPS];
    t_side       r_side [SQRT_STEPS];

    always_comb begin
        c_x[0]   = i_near.dist2;
        c_res[0] = 64'd0;
        for (int k = 1; k < SQRT_STEPS; k++) begin
            c_x[k]   = r_x[k-1];
            c_res[k] = r_res[k-1];
        end
        for (int k = 0; k < SQRT_STEPS; k++) begin
            c_bit[k] = 64'd1 << (62 - 2 * k);
            if (c_x[k] >= c_res[k] + c_bit[k]) begin
                n_x[k]   = c_x[k] - (c_res[k] + c_bit[k]);
                n_res[k] = (c_res[k] >> 1) + c_bit[k];
            end else begin
                n_x[k]   = c_x[k];
                n_res[k] = c_res[k] >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SQRT_STEPS; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < SQRT_STEPS; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_near.side;
            for (int k = 1; k < SQRT_STEPS; k++) begin
                r_side[k] <= r_side[k-1];
            end
            for (int k = 0; k < SQRT_STEPS; k++) begin
                r_x[k]   <= n_x[k];
                r_res[k] <= n_res[k];
            end
        end
    end

    assign o_valid     = r_vld[SQRT_STEPS-1];
    assign o_root.side = r_side[SQRT_STEPS-1];
    assign o_root.mag  = r_res[SQRT_STEPS-1][31:0];
endmodule
`default_nettype wire

// ----- rtl/scc_norm.sv -----
// Push direction by long division of each offset by the distance, then depth and
// the output register. Depends on scc_pkg.
`default_nettype none
module scc_norm import scc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_root i_root,
    output logic  o_valid,
    output t_res  o_res
);
    logic [2:0][46:0] c_rem  [NORM_STEPS];
    logic [2:0][14:0] c_q    [NORM_STEPS];
    logic [31:0]      c_dist [NORM_STEPS];
    logic [46:0]      c_trl  [NORM_STEPS];
    logic [2:0][46:0] n_rem  [NORM_STEPS];
    logic [2:0][14:0] n_q    [NORM_STEPS];
    t_res             n_out;
    logic [32:0]      n_diff;
    logic [14:0]      n_fq;

    logic             r_vld  [NORM_STEPS];
    logic [2:0][46:0] r_rem  [NORM_STEPS];
    logic [2:0][14:0] r_q    [NORM_STEPS];
    logic [31:0]      r_dist [NORM_STEPS];
    t_side            r_side [NORM_STEPS];
    logic             r_vld_out;
    t_res             r_out;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c_rem[0][i] = 47'({i_root.side.m[i], 14'd0});
        end
        c_q[0]    = '0;
        c_dist[0] = i_root.mag;
        for (int k = 1; k < NORM_STEPS; k++) begin
            c_rem[k]  = r_rem[k-1];
            c_q[k]    = r_q[k-1];
            c_dist[k] = r_dist[k-1];
        end
        for (int k = 0; k < NORM_STEPS; k++) begin
            c_trl[k] = 47'(c_dist[k]) << (NORM_STEPS - 1 - k);
            for (int i = 0; i < 3; i++) begin
                if (c_rem[k][i] >= c_trl[k]) begin
                    n_rem[k][i] = c_rem[k][i] - c_trl[k];
                    n_q[k][i]   = {c_q[k][i][13:0], 1'b1};
                end else begin
                    n_rem[k][i] = c_rem[k][i];
                    n_q[k][i]   = {c_q[k][i][13:0], 1'b0};
                end
            end
        end

        n_out.hit = r_side[NORM_STEPS-1].hit;
        n_diff    = {1'b0, r_side[NORM_STEPS-1].rsum} - {1'b0, r_dist[NORM_STEPS-1]};
        if (!n_out.hit) begin
            n_out.depth = 31'd0;
        end else if (n_diff[32:31] != 2'd0) begin
            n_out.depth = 31'h7FFF_FFFF;
        end else begin
            n_out.depth = n_diff[30:0];
        end
        for (int i = 0; i < 3; i++) begin
            n_fq = r_q[NORM_STEPS-1][i];
            if (!n_out.hit || r_side[NORM_STEPS-1].zero) begin
                n_out.push[i] = 16'd0;
            end else if (r_side[NORM_STEPS-1].neg[i]) begin
                n_out.push[i] = -{1'b0, n_fq};
            end else begin
                n_out.push[i] = {1'b0, n_fq};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NORM_STEPS; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_vld_out <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < NORM_STEPS; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_vld_out <= r_vld[NORM_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_root.side;
            for (int k = 1; k < NORM_STEPS; k++) begin
                r_side[k] <= r_side[k-1];
            end
            for (int k = 0; k < NORM_STEPS; k++) begin
                r_rem[k]  <= n_rem[k];
                r_q[k]    <= n_q[k];
                r_dist[k] <= c_dist[k];
            end
            r_out <= n_out;
        end
    end

    assign o_valid = r_vld_out;
    assign o_res   = r_out;
endmodule
`default_nettype wire

// ----- rtl/sphere_capsule_collision.sv -----
// Throughput: one item per cycle; the whole pipeline advances whenever the output
// register is empty or its item is taken, so a stall at the output holds every stage.
// Reset: i_rst_n synchronous, active low, clears all stage valid bits; data is not reset.
// Top level of the sphere/capsule overlap test; depends on scc_pkg and the scc_* stages.
`default_nettype none
module sphere_capsule_collision import scc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // sphere_x, sphere_y, sphere_z, sphere_radius, cap_center_x, cap_center_y,
    // cap_center_z, cap_dir_x, cap_dir_y, cap_dir_z, cap_length, cap_radius
    input  logic [335:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // push_x, push_y, push_z, depth
    output logic [79:0]  o_m_tdata,
    // hit
    output logic         o_m_tuser
);
    logic  w_en;
    t_item w_item;
    logic  w_vld_f, w_vld_t, w_vld_c, w_vld_s, w_vld_n;
    t_proj w_proj;
    t_para w_para;
    t_near w_near;
    t_root w_root;
    t_res  w_res;

    assign w_en       = !w_vld_n || i_m_tready;
    assign o_s_tready = w_en;
    assign w_item     = i_s_tdata[332:0];

    scc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(i_s_tvalid), .i_item(w_item),
        .o_valid(w_vld_f), .o_proj(w_proj)
    );

    scc_tdiv u_tdiv (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(w_vld_f), .i_proj(w_proj),
        .o_valid(w_vld_t), .o_para(w_para)
    );

    scc_close u_close (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(w_vld_t), .i_para(w_para),
        .o_valid(w_vld_c), .o_near(w_near)
    );

    scc_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(w_vld_c), .i_near(w_near),
        .o_valid(w_vld_s), .o_root(w_root)
    );

    scc_norm u_norm (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(w_vld_s), .i_root(w_root),
        .o_valid(w_vld_n), .o_res(w_res)
    );

    assign o_m_tvalid = w_vld_n;
    assign o_m_tdata  = {1'b0, w_res.depth, w_res.push[2], w_res.push[1], w_res.push[0]};
    assign o_m_tuser  = w_res.hit;
endmodule
`default_nettype wire

// ----- rtl/scc_check.sv -----
// Port-level checks for sphere_capsule_collision and the bind that attaches them.
// Depends on the top level's port list only.
`default_nettype none
module scc_check (
    input wire         i_clk,
    input wire         i_rst_n,
    input wire         o_s_tready,
    input wire         o_m_tvalid,
    input wire         i_m_tready,
    input wire [79:0]  o_m_tdata,
    input wire         o_m_tuser
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tuser))
        else $error("output item changed while stalled");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready == (!o_m_tvalid || i_m_tready))
        else $error("input ready does not follow output stall");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata == 80'd0)
        else $error("miss item carries nonzero fields");

    a_push_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> $signed(o_m_tdata[15:0]) <= 16'sd16384
                    && $signed(o_m_tdata[15:0]) >= -16'sd16384
                    && $signed(o_m_tdata[31:16]) <= 16'sd16384
                    && $signed(o_m_tdata[31:16]) >= -16'sd16384
                    && $signed(o_m_tdata[47:32]) <= 16'sd16384
                    && $signed(o_m_tdata[47:32]) >= -16'sd16384)
        else $error("push component out of unit range");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");
endmodule

bind sphere_capsule_collision scc_check u_scc_check (.*);
`default_nettype wire

// ----- dv/tb_sphere_capsule_collision.sv -----
// Testbench for sphere_capsule_collision: drives sphere/capsule pairs on the input stream,
// predicts each overlap result in fixed point and checks it on the output stream.
// Depends on scc_pkg and the sphere_capsule_collision RTL.
`default_nettype none
module tb_sphere_capsule_collision import scc_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic             hit;
        logic [2:0][15:0] push;
        logic [30:0]      depth;
    } t_overlap;

    class overlap_board;
        t_overlap pending[$];
        int       mismatches;

        static function automatic longint floor_sh(longint x, int s);
            return x >>> s;
        endfunction

        static function automatic longint sat_word(longint x);
            if (x > 64'sd2147483647) return 64'sd2147483647;
            if (x < -64'sd2147483648) return -64'sd2147483648;
            return x;
        endfunction

        static function automatic logic [63:0] root64(logic [63:0] x);
            logic [63:0] res;
            logic [63:0] bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > x) bitv = bitv >> 2;
            while (bitv != 0) begin
                if (x >= res + bitv) begin
                    x = x - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        function automatic t_overlap predict(t_item it);
            longint      s[3], c[3], dr[3], o[3], d[3], v[3];
            longint      e, en, a, b, len2, dp, t, p;
            logic [63:0] dist2, sq, m, rsum, r2, dlen, dep, q;
            logic [63:0] rem, qq;
            t_overlap    r;
            s[0] = longint'($signed(it.sphere_x));
            s[1] = longint'($signed(it.sphere_y));
            s[2] = longint'($signed(it.sphere_z));
            c[0] = longint'($signed(it.cap_center_x));
            c[1] = longint'($signed(it.cap_center_y));
            c[2] = longint'($signed(it.cap_center_z));
            dr[0] = longint'($signed(it.cap_dir_x));
            dr[1] = longint'($signed(it.cap_dir_y));
            dr[2] = longint'($signed(it.cap_dir_z));
            len2 = 0;
            dp = 0;
            for (int i = 0; i < 3; i++) begin
                e = floor_sh(dr[i] * longint'({33'd0, it.cap_length}), 15);
                en = sat_word(c[i] + e);
                o[i] = sat_word(c[i] - e);
                d[i] = en - o[i];
                a = floor_sh(d[i], 2);
                b = floor_sh(s[i] - o[i], 2);
                len2 += a * a;
                dp += a * b;
            end
            if (len2 == 0 || dp <= 0) begin
                t = 0;
            end else if (dp >= len2) begin
                t = 64'sd1 << 30;
            end else begin
                rem = dp;
                qq = 0;
                for (int i = 0; i < 30; i++) begin
                    rem = rem << 1;
                    qq = qq << 1;
                    if (rem >= len2) begin
                        rem = rem - len2;
                        qq[0] = 1'b1;
                    end
                end
                t = qq;
            end
            dist2 = 0;
            for (int i = 0; i < 3; i++) begin
                p = o[i] + floor_sh(d[i] * t, 30);
                v[i] = s[i] - p;
                m = (v[i] < 0) ? -v[i] : v[i];
                sq = m * m;
                dist2 = dist2 + sq;
                if (dist2 < sq) dist2 = '1;
            end
            rsum = {33'd0, it.sphere_radius} + {33'd0, it.cap_radius};
            r2 = rsum * rsum;
            r = '{1'b0, '0, '0};
            if (!(dist2 < r2)) return r;
            dlen = root64(dist2);
            r.hit = 1'b1;
            if (dist2 != 0) begin
                for (int i = 0; i < 3; i++) begin
                    m = (v[i] < 0) ? -v[i] : v[i];
                    q = (m << 14) / dlen;
                    if (v[i] < 0) q = -q;
                    r.push[i] = q[15:0];
                end
            end
            dep = rsum - dlen;
            if (dep > 64'h7FFF_FFFF) dep = 64'h7FFF_FFFF;
            r.depth = dep[30:0];
            return r;
        endfunction

        function void note_pair(t_item it);
            pending.push_back(predict(it));
        endfunction

        function void check_result(logic hit, logic [79:0] data);
            t_overlap x;
            t_overlap got;
            got.hit = hit;
            got.push[0] = data[15:0];
            got.push[1] = data[31:16];
            got.push[2] = data[47:32];
            got.depth = data[78:48];
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result hit=%0d data=%h", hit, data);
                return;
            end
            x = pending.pop_front();
            if (x.hit !== got.hit || x.push !== got.push || x.depth !== got.depth
                    || data[79] !== 1'b0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp hit=%0d push=%h depth=%h got hit=%0d push=%h depth=%h",
                             x.hit, x.push, x.depth, got.hit, got.push, got.depth);
            end
        endfunction
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [335:0] i_s_tdata = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [79:0]  o_m_tdata;
    logic         o_m_tuser;
    bit           calm;
    overlap_board board = new();

    sphere_capsule_collision DUT (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
            default: return 32'($signed($urandom_range(0, 4000 << 16)) - (2000 << 16));
        endcase
    endfunction

    function automatic t_item rand_pair();
        t_item it;
        int    md;
        logic [15:0] ax;
        md = $urandom_range(0, 9) == 0 ? 0 : ($urandom_range(0, 3) == 0 ? 2 : 1);
        it.sphere_x = rand_coord(md);
        it.sphere_y = rand_coord(md);
        it.sphere_z = rand_coord(md);
        it.cap_center_x = rand_coord(md);
        it.cap_center_y = rand_coord(md);
        it.cap_center_z = rand_coord(md);
        if (md == 0) begin
            it.sphere_radius = 31'($urandom);
            it.cap_length = 31'($urandom);
            it.cap_radius = 31'($urandom);
            it.cap_dir_x = 16'($urandom);
            it.cap_dir_y = 16'($urandom);
            it.cap_dir_z = 16'($urandom);
        end else begin
            it.sphere_radius = 31'($urandom_range(0, 8 << 16));
            it.cap_length = 31'($urandom_range(0, 12 << 16));
            it.cap_radius = 31'($urandom_range(0, 8 << 16));
            ax = 16'($signed($urandom_range(0, 32768)) - 16384);
            case ($urandom_range(0, 3))
                0: begin it.cap_dir_x = ax; it.cap_dir_y = 16'($urandom_range(0, 200));
                   it.cap_dir_z = 0; end
                1: begin it.cap_dir_x = 11585; it.cap_dir_y = 16'(ax[15] ? -11585 : 11585);
                   it.cap_dir_z = 0; end
                2: begin it.cap_dir_x = 9459; it.cap_dir_y = 9459;
                   it.cap_dir_z = 16'(ax[15] ? -9459 : 9459); end
                default: begin it.cap_dir_x = 16'($urandom); it.cap_dir_y = 16'($urandom);
                   it.cap_dir_z = 16'($urandom_range(0, 16384)); end
            endcase
        end
        return it;
    endfunction

    function automatic t_item make_pair(logic [31:0] sx, sy, sz, logic [30:0] rs,
            logic [31:0] cx, logic [15:0] dx, dy, logic [30:0] len, rc);
        t_item it;
        it = '0;
        it.sphere_x = sx; it.sphere_y = sy; it.sphere_z = sz; it.sphere_radius = rs;
        it.cap_center_x = cx; it.cap_dir_x = dx; it.cap_dir_y = dy;
        it.cap_length = len; it.cap_radius = rc;
        return it;
    endfunction

    task automatic send_pair(t_item it);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {3'b000, it.cap_radius, it.cap_length, it.cap_dir_z, it.cap_dir_y,
                      it.cap_dir_x, it.cap_center_z, it.cap_center_y, it.cap_center_x,
                      it.sphere_radius, it.sphere_z, it.sphere_y, it.sphere_x};
        do @(posedge i_clk); while (!o_s_tready);
        board.note_pair(it);
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) board.check_result(o_m_tuser, o_m_tdata);
    end

    initial begin
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 4) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 4) - 1) @(negedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    initial begin
        t_item it;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        send_pair(make_pair(0, 0, 0, 31'h7FFF_FFFF, 0, 16384, 0, 31'h7FFF_FFFF,
                            31'h7FFF_FFFF));
        send_pair(make_pair(0, 0, 0, 0, 0, 16384, 0, 1 << 16, 0));
        send_pair(make_pair(2 << 16, 0, 0, 1 << 16, 0, 16384, 0, 0, 1 << 16));
        send_pair(make_pair(1 << 16, 1 << 16, 0, 1 << 16, 0, 16384, 0, 4 << 16, 1 << 16));
        send_pair(make_pair(9 << 16, 0, 0, 1 << 16, 0, 16384, 0, 4 << 16, 1 << 16));
        send_pair(make_pair(-(9 << 16), 0, 1 << 15, 1 << 16, 0, 16384, 0, 4 << 16, 1 << 16));
        send_pair(make_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
                            32'h8000_0000, 16'h8000, 16'h7FFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF));
        send_pair(make_pair(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF,
                            16'h7FFF, 16'h8000, 31'h7FFF_FFFF, 0));
        send_pair(make_pair(0, 3 << 16, 0, 31'h7FFF_FFFF, 0, -16384, 0, 8 << 16, 5));
        send_pair(make_pair(0, 32'hFFFF_FFFF, 0, 0, 0, 0, 16384, 31'h7FFF_FFFF, 1));
        send_pair(make_pair(1, 32'hFFFF_FFFF, 1, 31'h4000_0000, 0, 16'hFFFF, 16'hFFFF,
                            31'h5555_5555, 31'h2AAA_AAAA));
        it = '1;
        send_pair(it);
        i_s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
        for (int n = 0; n < 440; n++) begin
            if (n == 380) calm = 1'b1;
            send_pair(rand_pair());
        end
        i_s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("[sphere_capsule_collision] OK");
        end else begin
            $display("[sphere_capsule_collision] ERROR");
        end
        $finish;
    end

    initial begin
        #400us;
        $display("[sphere_capsule_collision] ERROR");
        $finish;
    end
endmodule
`default_nettype wire
